/* design/edc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package edc_pkg;
  localparam int DW = 32;
  localparam int VW = 17;
endpackage
`default_nettype wire

/* design/edc_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
interface edc_mat_if;
  logic                          valid;
  logic                          ready;
  logic signed [edc_pkg::DW-1:0] a00;
  logic signed [edc_pkg::DW-1:0] a01;
  logic signed [edc_pkg::DW-1:0] a10;
  logic signed [edc_pkg::DW-1:0] a11;
  modport source (output valid, output a00, output a01, output a10, output a11, input ready);
  modport sink (input valid, input a00, input a01, input a10, input a11, output ready);
endinterface

interface edc_res_if;
  logic                          valid;
  logic                          ready;
  logic signed [edc_pkg::DW-1:0] eig_major;
  logic signed [edc_pkg::DW-1:0] eig_minor;
  logic signed [edc_pkg::VW-1:0] v1_x;
  logic signed [edc_pkg::VW-1:0] v1_y;
  logic signed [edc_pkg::VW-1:0] v2_x;
  logic signed [edc_pkg::VW-1:0] v2_y;
  logic                          complex_flag;
  logic                          degenerate_flag;
  modport source (output valid, output eig_major, output eig_minor, output v1_x, output v1_y,
                  output v2_x, output v2_y, output complex_flag, output degenerate_flag,
                  input ready);
  modport sink (input valid, input eig_major, input eig_minor, input v1_x, input v1_y,
                input v2_x, input v2_y, input complex_flag, input degenerate_flag,
                output ready);
endinterface
`default_nettype wire

/* design/edc_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module edc_isqrt #(
  parameter int IW = 64,
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IW-1:0]     in_val,
  input  logic [PW-1:0]     in_pay,
  output logic              out_vld,
  output logic [IW/2-1:0]   out_root,
  output logic [PW-1:0]     out_pay
);
  localparam int NS = IW / 2;

  logic [IW-1:0] rem  [NS];
  logic [IW-1:0] root [NS];
  logic [PW-1:0] pay  [NS];
  logic          vld  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam logic [IW-1:0] BITV = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2 * s);
    logic [IW-1:0] prem;
    logic [IW-1:0] proot;
    logic [PW-1:0] ppay;
    logic          pvld;
    logic [IW-1:0] trial;
    logic [IW-1:0] nrem;
    logic [IW-1:0] nroot;

    if (s == 0) begin : g_first
      assign prem  = in_val;
      assign proot = '0;
      assign ppay  = in_pay;
      assign pvld  = in_vld;
    end else begin : g_next
      assign prem  = rem[s-1];
      assign proot = root[s-1];
      assign ppay  = pay[s-1];
      assign pvld  = vld[s-1];
    end

    always_comb begin
      trial = proot + BITV;
      if (prem >= trial) begin
        nrem  = prem - trial;
        nroot = (proot >> 1) + BITV;
      end else begin
        nrem  = prem;
        nroot = proot >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pvld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= nrem;
        root[s] <= nroot;
        pay[s]  <= ppay;
      end
    end
  end

  assign out_vld  = vld[NS-1];
  assign out_root = root[NS-1][NS-1:0];
  assign out_pay  = pay[NS-1];
endmodule
`default_nettype wire

/* design/eigen_decomposition_2x2.sv */
`timescale 1ns / 1ps
`default_nettype none
// Closed-form 2x2 eigen decomposition. One matrix (four signed Q16.16 entries) is taken
// every cycle while ready is high; on its way out its result beat passes through
// two 32-stage square-root pipelines (discriminant, then vector length) and a 17-stage
// divider for the Q1.15 unit vectors. Eigenvalues are ordered by magnitude, largest first,
// and saturated to 32 bits. A negative discriminant gives complex_flag with all else zero;
// a zero-length vector comes out as zero with degenerate_flag set. A two-beat output
// buffer lets the pipeline keep moving while a result waits; ready drops only when it is full.
module eigen_decomposition_2x2 (
  input  logic       clk,
  input  logic       rst,
  edc_mat_if.sink    mat,
  edc_res_if.source  res
);
  localparam int DW  = edc_pkg::DW;
  localparam int VW  = edc_pkg::VW;
  localparam int QW  = 2 * DW;
  localparam int LW  = DW + 4;
  localparam int CW  = LW + 1;
  localparam int MG  = CW - 1;
  localparam int MW  = DW - 1;
  localparam int KW  = $clog2(MG - MW + 1);
  localparam int SW  = 2 * MW;
  localparam int RW  = DW;
  localparam int QN  = VW - 1;
  localparam int DVW = MW + QN + 1;
  localparam int PAW = 5 * DW + 2;
  localparam int PBW = 2 * DW + 4 + 2 * MW;
  localparam int PCW = 3 + 2 * MW;

  typedef struct packed {
    logic [DW-1:0] eig_major;
    logic [DW-1:0] eig_minor;
    logic [VW-1:0] v1_x;
    logic [VW-1:0] v1_y;
    logic [VW-1:0] v2_x;
    logic [VW-1:0] v2_y;
    logic          complex_flag;
    logic          degenerate_flag;
  } res_t;

  typedef struct packed {
    logic [3:0][DVW-1:0] rem;
    logic [3:0][QN-1:0]  quo;
    logic [1:0][RW-1:0]  den;
    logic [3:0]          sg;
    logic [1:0]          z;
    logic [DW-1:0]       emaj;
    logic [DW-1:0]       emin;
    logic                cplx;
  } dv_t;

  function automatic logic [CW-1:0] sxd(input logic [DW-1:0] v);
    return {{(CW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [CW-1:0] sxl(input logic [LW-1:0] v);
    return {{(CW-LW){v[LW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] sat_dw(input logic [LW-1:0] v);
    logic ovf;
    ovf = (v[LW-1:DW-1] != {(LW-DW+1){v[LW-1]}});
    if (ovf) begin
      return v[LW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return v[DW-1:0];
  endfunction

  logic adv;

  // stage 1
  logic          v1;
  logic [DW-1:0] s1_a00, s1_a01, s1_a10, s1_a11, s1_ud;
  logic [DW:0]   in_diff, in_neg;
  logic [DW-1:0] in_ud;

  assign in_diff = {mat.a00[DW-1], mat.a00} - {mat.a11[DW-1], mat.a11};
  assign in_neg  = -in_diff;
  assign in_ud   = in_diff[DW] ? in_neg[DW-1:0] : in_diff[DW-1:0];

  // stage 2
  logic                 v2;
  logic [DW-1:0]        s2_a00, s2_a01, s2_a10, s2_a11;
  logic [DW:0]          s2_tr;
  logic [QW-1:0]        s2_dsq;
  logic signed [QW-1:0] s2_prd;
  logic [QW-1:0]        dsq_c;
  logic signed [QW-1:0] prd_c;

  assign dsq_c = s1_ud * s1_ud;
  assign prd_c = $signed(s1_a01) * $signed(s1_a10);

  // stage 3
  logic          v3;
  logic [DW-1:0] s3_a00, s3_a01, s3_a10, s3_a11;
  logic [DW:0]   s3_tr;
  logic [QW-1:0] s3_q;
  logic [QW-1:0] q_c;

  assign q_c = {2'b00, s2_dsq[QW-1:2]} + s2_prd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= mat.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a00 <= mat.a00;
      s1_a01 <= mat.a01;
      s1_a10 <= mat.a10;
      s1_a11 <= mat.a11;
      s1_ud  <= in_ud;
      s2_a00 <= s1_a00;
      s2_a01 <= s1_a01;
      s2_a10 <= s1_a10;
      s2_a11 <= s1_a11;
      s2_tr  <= {s1_a00[DW-1], s1_a00} + {s1_a11[DW-1], s1_a11};
      s2_dsq <= dsq_c;
      s2_prd <= prd_c;
      s3_a00 <= s2_a00;
      s3_a01 <= s2_a01;
      s3_a10 <= s2_a10;
      s3_a11 <= s2_a11;
      s3_tr  <= s2_tr;
      s3_q   <= q_c;
    end
  end

  // discriminant root
  logic           r_vld;
  logic [RW-1:0]  r_root;
  logic [PAW-1:0] r_pay;
  logic [DW-1:0]  p_a00, p_a01, p_a10, p_a11;
  logic [DW:0]    p_tr;
  logic           p_cplx;

  edc_isqrt #(.IW(QW), .PW(PAW)) u_sqrt_q (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v3),
    .in_val   (s3_q),
    .in_pay   ({s3_a00, s3_a01, s3_a10, s3_a11, s3_tr, s3_q[QW-1]}),
    .out_vld  (r_vld),
    .out_root (r_root),
    .out_pay  (r_pay)
  );

  assign {p_a00, p_a01, p_a10, p_a11, p_tr, p_cplx} = r_pay;

  // stage 4: eigenvalues
  logic          v4;
  logic [DW-1:0] s4_a00, s4_a01, s4_a10, s4_a11;
  logic          s4_cplx;
  logic [LW-1:0] s4_lp, s4_lm;
  logic [LW-1:0] tr_c, r2_c, lp_sum, lm_sum;

  assign tr_c   = {{(LW-DW-1){p_tr[DW]}}, p_tr};
  assign r2_c   = {{(LW-DW-1){1'b0}}, r_root, 1'b0};
  assign lp_sum = tr_c + r2_c;
  assign lm_sum = tr_c - r2_c;

  // stage 5: order by magnitude
  logic          v5;
  logic [DW-1:0] s5_a00, s5_a01, s5_a10, s5_a11;
  logic          s5_cplx;
  logic [LW-1:0] s5_maj, s5_min;
  logic [LW-1:0] lp_neg, lm_neg, lp_mag, lm_mag;
  logic          swap_c;

  assign lp_neg = -s4_lp;
  assign lm_neg = -s4_lm;
  assign lp_mag = s4_lp[LW-1] ? lp_neg : s4_lp;
  assign lm_mag = s4_lm[LW-1] ? lm_neg : s4_lm;
  assign swap_c = lp_mag < lm_mag;

  // stage 6: saturation and raw vectors (x1, y1, x2, y2)
  logic                v6;
  logic                s6_cplx;
  logic [DW-1:0]       s6_maj, s6_min;
  logic [3:0][CW-1:0]  s6_c;

  // stage 7: sign and magnitude
  logic                v7;
  logic                s7_cplx;
  logic [DW-1:0]       s7_maj, s7_min;
  logic [3:0]          s7_sg;
  logic [3:0][MG-1:0]  s7_m;
  logic [3:0][CW-1:0]  neg_c;

  // stage 8: scale below 2^31
  logic                v8;
  logic                s8_cplx;
  logic [DW-1:0]       s8_maj, s8_min;
  logic [3:0]          s8_sg;
  logic [1:0]          s8_z;
  logic [3:0][MW-1:0]  s8_m;
  logic [1:0][MG-1:0]  or_c;
  logic [1:0][KW-1:0]  k_c;

  // stage 9: squares
  logic                v9;
  logic                s9_cplx;
  logic [DW-1:0]       s9_maj, s9_min;
  logic [3:0]          s9_sg;
  logic [1:0]          s9_z;
  logic [3:0][MW-1:0]  s9_m;
  logic [3:0][SW-1:0]  s9_sq;

  // stage 10: squared lengths
  logic                v10;
  logic                s10_cplx;
  logic [DW-1:0]       s10_maj, s10_min;
  logic [3:0]          s10_sg;
  logic [1:0]          s10_z;
  logic [3:0][MW-1:0]  s10_m;
  logic [1:0][SW:0]    s10_n2;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      neg_c[l] = -s6_c[l];
    end
    for (int j = 0; j < 2; j++) begin
      or_c[j] = s7_m[2*j] | s7_m[2*j+1];
      k_c[j]  = '0;
      for (int p = MW; p < MG; p++) begin
        if (or_c[j][p]) begin
          k_c[j] = KW'(p - MW + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (adv) begin
      v4  <= r_vld;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_a00  <= p_a00;
      s4_a01  <= p_a01;
      s4_a10  <= p_a10;
      s4_a11  <= p_a11;
      s4_cplx <= p_cplx;
      s4_lp   <= {lp_sum[LW-1], lp_sum[LW-1:1]};
      s4_lm   <= {lm_sum[LW-1], lm_sum[LW-1:1]};

      s5_a00  <= s4_a00;
      s5_a01  <= s4_a01;
      s5_a10  <= s4_a10;
      s5_a11  <= s4_a11;
      s5_cplx <= s4_cplx;
      s5_maj  <= swap_c ? s4_lm : s4_lp;
      s5_min  <= swap_c ? s4_lp : s4_lm;

      s6_cplx <= s5_cplx;
      s6_maj  <= sat_dw(s5_maj);
      s6_min  <= sat_dw(s5_min);
      s6_c[0] <= sxd(s5_a01);
      s6_c[1] <= sxl(s5_maj) - sxd(s5_a00);
      s6_c[2] <= sxd(s5_a11) - sxl(s5_min);
      s6_c[3] <= '0 - sxd(s5_a10);

      s7_cplx <= s6_cplx;
      s7_maj  <= s6_maj;
      s7_min  <= s6_min;
      for (int l = 0; l < 4; l++) begin
        s7_sg[l] <= s6_c[l][CW-1];
        s7_m[l]  <= s6_c[l][CW-1] ? neg_c[l][MG-1:0] : s6_c[l][MG-1:0];
      end

      s8_cplx <= s7_cplx;
      s8_maj  <= s7_maj;
      s8_min  <= s7_min;
      s8_sg   <= s7_sg;
      for (int j = 0; j < 2; j++) begin
        s8_z[j] <= (or_c[j] == '0);
      end
      for (int l = 0; l < 4; l++) begin
        s8_m[l] <= MW'(s7_m[l] >> k_c[l/2]);
      end

      s9_cplx <= s8_cplx;
      s9_maj  <= s8_maj;
      s9_min  <= s8_min;
      s9_sg   <= s8_sg;
      s9_z    <= s8_z;
      s9_m    <= s8_m;
      for (int l = 0; l < 4; l++) begin
        s9_sq[l] <= s8_m[l] * s8_m[l];
      end

      s10_cplx <= s9_cplx;
      s10_maj  <= s9_maj;
      s10_min  <= s9_min;
      s10_sg   <= s9_sg;
      s10_z    <= s9_z;
      s10_m    <= s9_m;
      for (int j = 0; j < 2; j++) begin
        s10_n2[j] <= {1'b0, s9_sq[2*j]} + {1'b0, s9_sq[2*j+1]};
      end
    end
  end

  // vector lengths
  logic           na_vld, nb_vld;
  logic [RW-1:0]  na_root, nb_root;
  logic [PBW-1:0] na_pay;
  logic [PCW-1:0] nb_pay;
  logic [DW-1:0]  n_maj, n_min;
  logic           n_cplx;
  logic [3:0]     n_sg;
  logic [1:0]     n_z;
  logic [3:0][MW-1:0] n_m;

  edc_isqrt #(.IW(QW), .PW(PBW)) u_sqrt_v1 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v10),
    .in_val   ({1'b0, s10_n2[0]}),
    .in_pay   ({s10_maj, s10_min, s10_cplx, s10_z[0], s10_sg[1:0], s10_m[0], s10_m[1]}),
    .out_vld  (na_vld),
    .out_root (na_root),
    .out_pay  (na_pay)
  );

  edc_isqrt #(.IW(QW), .PW(PCW)) u_sqrt_v2 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v10),
    .in_val   ({1'b0, s10_n2[1]}),
    .in_pay   ({s10_z[1], s10_sg[3:2], s10_m[2], s10_m[3]}),
    .out_vld  (nb_vld),
    .out_root (nb_root),
    .out_pay  (nb_pay)
  );

  assign {n_maj, n_min, n_cplx, n_z[0], n_sg[1:0], n_m[0], n_m[1]} = na_pay;
  assign {n_z[1], n_sg[3:2], n_m[2], n_m[3]} = nb_pay;

  // divider: round(|c| * 2^15 / n), one quotient bit per stage
  dv_t        dv  [QN+1];
  dv_t        dvn [QN+1];
  logic       dvv [QN+1];

  always_comb begin
    dvn[0]        = '0;
    dvn[0].den[0] = na_root;
    dvn[0].den[1] = nb_root;
    dvn[0].sg     = n_sg;
    dvn[0].z      = n_z;
    dvn[0].emaj   = n_maj;
    dvn[0].emin   = n_min;
    dvn[0].cplx   = n_cplx;
    for (int l = 0; l < 4; l++) begin
      dvn[0].rem[l] = DVW'({n_m[l], {(QN-1){1'b0}}}) +
                      DVW'(((l < 2) ? na_root : nb_root) >> 1);
    end
  end

  for (genvar j = 1; j <= QN; j++) begin : g_div
    localparam int SH = QN - j;
    logic [3:0][DVW-1:0] sub;

    always_comb begin
      dvn[j] = dv[j-1];
      for (int l = 0; l < 4; l++) begin
        sub[l] = DVW'(dv[j-1].den[l/2]) << SH;
        if (dv[j-1].rem[l] >= sub[l]) begin
          dvn[j].rem[l]     = dv[j-1].rem[l] - sub[l];
          dvn[j].quo[l][SH] = 1'b1;
        end
      end
    end
  end

  for (genvar j = 0; j <= QN; j++) begin : g_dvreg
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j] <= 1'b0;
      end else if (adv) begin
        dvv[j] <= (j == 0) ? (na_vld & nb_vld) : dvv[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j] <= dvn[j];
      end
    end
  end

  // result assembly
  res_t                fin;
  logic [3:0][VW-1:0]  cmp_c;
  logic [3:0][VW-1:0]  cneg_c;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cmp_c[l]  = {1'b0, dv[QN].quo[l]};
      cneg_c[l] = -cmp_c[l];
      if (dv[QN].cplx || dv[QN].z[l/2]) begin
        cmp_c[l] = '0;
      end else if (dv[QN].sg[l]) begin
        cmp_c[l] = cneg_c[l];
      end
    end
    fin.eig_major       = dv[QN].cplx ? '0 : dv[QN].emaj;
    fin.eig_minor       = dv[QN].cplx ? '0 : dv[QN].emin;
    fin.v1_x            = cmp_c[0];
    fin.v1_y            = cmp_c[1];
    fin.v2_x            = cmp_c[2];
    fin.v2_y            = cmp_c[3];
    fin.complex_flag    = dv[QN].cplx;
    fin.degenerate_flag = !dv[QN].cplx && (dv[QN].z[0] || dv[QN].z[1]);
  end

  // two-beat output buffer
  res_t       obuf [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign adv  = (cnt != 2'd2);
  assign push = adv && dvv[QN];
  assign pop  = (cnt != 2'd0) && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wp] <= fin;
    end
  end

  assign mat.ready           = adv;
  assign res.valid           = (cnt != 2'd0);
  assign res.eig_major       = obuf[rp].eig_major;
  assign res.eig_minor       = obuf[rp].eig_minor;
  assign res.v1_x            = obuf[rp].v1_x;
  assign res.v1_y            = obuf[rp].v1_y;
  assign res.v2_x            = obuf[rp].v2_x;
  assign res.v2_y            = obuf[rp].v2_y;
  assign res.complex_flag    = obuf[rp].complex_flag;
  assign res.degenerate_flag = obuf[rp].degenerate_flag;
endmodule
`default_nettype wire

/* bench/tb_eigen_decomposition_2x2.sv */
`timescale 1ns / 1ps
module tb_eigen_decomposition_2x2;
  localparam int DW         = edc_pkg::DW;
  localparam int VW         = edc_pkg::VW;
  localparam int N_RANDOM   = 1930;
  localparam int CALM_AFTER = 1750;
  localparam int LATENCY    = 92;
  localparam int CYCLE_MAX  = 300000;

  typedef struct packed {
    logic signed [DW-1:0] eig_major;
    logic signed [DW-1:0] eig_minor;
    logic signed [VW-1:0] v1_x;
    logic signed [VW-1:0] v1_y;
    logic signed [VW-1:0] v2_x;
    logic signed [VW-1:0] v2_y;
    logic                 complex_flag;
    logic                 degenerate_flag;
  } eigen_t;

  class eigen_scoreboard;
    eigen_t expected_q[$];
    int     errors = 0;

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit unit_vector(longint x, longint y, output logic [VW-1:0] ox,
                             output logic [VW-1:0] oy);
      longint unsigned mx, my, n, rx, ry;
      mx = mag(x);
      my = mag(y);
      ox = '0;
      oy = '0;
      if (mx == 0 && my == 0) return 1'b1;
      while ((mx >> 31) != 0 || (my >> 31) != 0) begin
        mx >>= 1;
        my >>= 1;
      end
      n  = isqrt(mx * mx + my * my);
      rx = (mx * 32768 + n / 2) / n;
      ry = (my * 32768 + n / 2) / n;
      ox = (x < 0) ? VW'(-rx) : VW'(rx);
      oy = (y < 0) ? VW'(-ry) : VW'(ry);
      return 1'b0;
    endfunction

    function void note_matrix(logic signed [DW-1:0] a00, logic signed [DW-1:0] a01,
                              logic signed [DW-1:0] a10, logic signed [DW-1:0] a11);
      eigen_t e;
      longint x00, x01, x10, x11, tr, q, r, lp, lm, t;
      longint unsigned ud;
      bit dg1, dg2;
      x00 = a00; x01 = a01; x10 = a10; x11 = a11;
      e = '0;
      tr = x00 + x11;
      ud = mag(x00 - x11);
      q = longint'((ud * ud) >> 2) + x01 * x10;
      if (q < 0) begin
        e.complex_flag = 1'b1;
      end else begin
        r  = longint'(isqrt(longint'(q)));
        lp = (tr + 2 * r) >>> 1;
        lm = (tr - 2 * r) >>> 1;
        if (mag(lp) < mag(lm)) begin
          t = lp; lp = lm; lm = t;
        end
        e.eig_major = DW'(clamp(lp));
        e.eig_minor = DW'(clamp(lm));
        dg1 = unit_vector(x01, lp - x00, e.v1_x, e.v1_y);
        dg2 = unit_vector(x11 - lm, -x10, e.v2_x, e.v2_y);
        e.degenerate_flag = dg1 | dg2;
      end
      expected_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(eigen_t got);
      eigen_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result beat", 0, 0);
        return;
      end
      w = expected_q.pop_front();
      if (got.eig_major !== w.eig_major) report("eig_major", got.eig_major, w.eig_major);
      if (got.eig_minor !== w.eig_minor) report("eig_minor", got.eig_minor, w.eig_minor);
      if (got.v1_x !== w.v1_x) report("v1_x", got.v1_x, w.v1_x);
      if (got.v1_y !== w.v1_y) report("v1_y", got.v1_y, w.v1_y);
      if (got.v2_x !== w.v2_x) report("v2_x", got.v2_x, w.v2_x);
      if (got.v2_y !== w.v2_y) report("v2_y", got.v2_y, w.v2_y);
      if (got.complex_flag !== w.complex_flag)
        report("complex_flag", got.complex_flag, w.complex_flag);
      if (got.degenerate_flag !== w.degenerate_flag)
        report("degenerate_flag", got.degenerate_flag, w.degenerate_flag);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  edc_mat_if mat ();
  edc_res_if res ();

  eigen_decomposition_2x2 i_dut (.clk(clk), .rst(rst), .mat(mat), .res(res));

  eigen_scoreboard sb = new();
  int  sent = 0;
  int  cycles = 0;
  bit  hold_rx = 1'b0;
  bit  calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    mat.valid = 1'b0;
    mat.a00 = '0; mat.a01 = '0; mat.a10 = '0; mat.a11 = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("[eigen_decomposition_2x2] ERROR");
      $finish;
    end
    if (!rst && mat.valid && mat.ready) sb.note_matrix(mat.a00, mat.a01, mat.a10, mat.a11);
    if (!rst && res.valid && res.ready)
      sb.check_result({res.eig_major, res.eig_minor, res.v1_x, res.v1_y, res.v2_x, res.v2_y,
                       res.complex_flag, res.degenerate_flag});
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (sent >= 300);
    @(negedge clk);
    hold_rx = 1'b1;
    repeat (400) @(negedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    int gap;
    gap = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (gap == 0 && !calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) gap--;
      res.ready <= !hold_rx && (gap == 0);
    end
  end

  task automatic send_matrix(logic [DW-1:0] a00, logic [DW-1:0] a01, logic [DW-1:0] a10,
                             logic [DW-1:0] a11);
    mat.valid <= 1'b1;
    mat.a00 <= a00; mat.a01 <= a01; mat.a10 <= a10; mat.a11 <= a11;
    do @(posedge clk); while (!mat.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      mat.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  function automatic logic [DW-1:0] pick_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return DW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return DW'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [DW-1:0] b00, b01, b10, b11;
    int kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_matrix(0, 0, 0, 0);
    send_matrix(32'h0001_0000, 0, 0, 32'h0001_0000);
    send_matrix(32'h0002_0000, 0, 0, 32'h0001_0000);
    send_matrix(32'h0001_0000, 0, 0, 32'hFFFF_0000);
    send_matrix(0, 32'h0001_0000, 32'hFFFF_0000, 0);
    send_matrix(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000);
    send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
    send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_matrix(32'h0003_0000, 32'h0001_0000, 0, 32'h0003_0000);
    send_matrix(32'h0003_0000, 0, 32'h0001_0000, 32'h0003_0000);
    send_matrix(32'hFFFD_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 600) begin
        mat.valid <= 1'b0;
        wait (sb.expected_q.size() == 0);
        @(negedge clk);
      end
      if (i == CALM_AFTER) calm = 1'b1;
      kind = $urandom_range(0, 4);
      b00 = pick_entry(kind); b01 = pick_entry(kind);
      b10 = pick_entry(kind); b11 = pick_entry(kind);
      if ($urandom_range(0, 3) == 0) b10 = b01;
      send_matrix(b00, b01, b10, b11);
      idle_gap();
    end
    mat.valid <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[eigen_decomposition_2x2] OK");
    end else begin
      $display("[eigen_decomposition_2x2] ERROR");
    end
    $finish;
  end
endmodule
